// File: design/jsfh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jsfh_pkg;

  localparam int CNT_W       = 7;
  localparam int ALLELE_W    = 64;
  localparam int BIN_W       = 32;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CHUNK_W     = 8;
  localparam int CHUNKS      = ALLELE_W / CHUNK_W;
  localparam int CHUNK_CNT_W = 4;

  localparam logic CMD_TALLY = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POP1 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POP2 = 1'd1;

  localparam logic [CNT_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [BIN_W-1:0] BIN_MAX    = '1;

  typedef struct packed {
    logic             cmd;
    logic             ok;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } jsfh_item_t;

  function automatic logic [ALLELE_W-1:0] low_mask(input logic [CNT_W-1:0] size);
    logic [ALLELE_W-1:0] m;
    m = '0;
    for (int k = 0; k < ALLELE_W; k++) begin
      m[k] = (CNT_W'(k) < size);
    end
    return m;
  endfunction

  function automatic logic [CHUNK_CNT_W-1:0] popcnt8(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      n = n + CHUNK_CNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: design/jsfh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface jsfh_in_if
  import jsfh_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ALLELE_W-1:0] pop1_alleles;
  logic [ALLELE_W-1:0] pop2_alleles;
  logic [CNT_W-1:0]    read_row;
  logic [CNT_W-1:0]    read_col;

  modport source (output valid, cmd, pop1_alleles, pop2_alleles, read_row, read_col,
                  input ready);
  modport sink (input valid, cmd, pop1_alleles, pop2_alleles, read_row, read_col,
                output ready);
endinterface
`default_nettype wire

// File: design/jsfh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface jsfh_out_if
  import jsfh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] freq_pop1;
  logic [CNT_W-1:0] freq_pop2;
  logic [BIN_W-1:0] bin_value;
  logic [BIN_W-1:0] total_sites;

  modport source (output valid, freq_pop1, freq_pop2, bin_value, total_sites,
                  input ready);
  modport sink (input valid, freq_pop1, freq_pop2, bin_value, total_sites,
                output ready);
endinterface
`default_nettype wire

// File: design/jsfh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module jsfh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4225,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/jsfh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module jsfh_front
  import jsfh_pkg::*;
#(
  parameter int MAX_POP_SIZE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             busy,
  input  wire logic [CNT_W-1:0] pop1_size,
  input  wire logic [CNT_W-1:0] pop2_size,
  jsfh_in_if.sink               sites,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output jsfh_item_t            push_item
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POP_SIZE);

  logic                   f1_valid;
  logic                   f1_cmd;
  logic [CNT_W-1:0]       f1_row;
  logic [CNT_W-1:0]       f1_col;
  logic [CHUNK_CNT_W-1:0] f1_cnt1 [CHUNKS];
  logic [CHUNK_CNT_W-1:0] f1_cnt2 [CHUNKS];

  logic [CNT_W-1:0]       size1;
  logic [CNT_W-1:0]       size2;
  logic [ALLELE_W-1:0]    masked1;
  logic [ALLELE_W-1:0]    masked2;
  logic [CHUNK_CNT_W-1:0] cnt1_next [CHUNKS];
  logic [CHUNK_CNT_W-1:0] cnt2_next [CHUNKS];
  logic [CNT_W-1:0]       sum1;
  logic [CNT_W-1:0]       sum2;
  logic                   accept;

  assign sites.ready = !busy && (!f1_valid || push_ready);
  assign accept      = sites.valid && sites.ready;

  assign size1   = (pop1_size > MAX_CNT) ? MAX_CNT : pop1_size;
  assign size2   = (pop2_size > MAX_CNT) ? MAX_CNT : pop2_size;
  assign masked1 = sites.pop1_alleles & low_mask(size1);
  assign masked2 = sites.pop2_alleles & low_mask(size2);

  always_comb begin
    for (int i = 0; i < CHUNKS; i++) begin
      cnt1_next[i] = popcnt8(masked1[i*CHUNK_W +: CHUNK_W]);
      cnt2_next[i] = popcnt8(masked2[i*CHUNK_W +: CHUNK_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push_ready) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_cmd  <= sites.cmd;
      f1_row  <= sites.read_row;
      f1_col  <= sites.read_col;
      f1_cnt1 <= cnt1_next;
      f1_cnt2 <= cnt2_next;
    end
  end

  always_comb begin
    sum1 = '0;
    sum2 = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      sum1 = sum1 + CNT_W'(f1_cnt1[i]);
      sum2 = sum2 + CNT_W'(f1_cnt2[i]);
    end
  end

  always_comb begin
    push_item.cmd = f1_cmd;
    if (f1_cmd == CMD_TALLY) begin
      push_item.ok  = 1'b1;
      push_item.row = sum1;
      push_item.col = sum2;
    end else begin
      push_item.ok  = (f1_row <= MAX_CNT) && (f1_col <= MAX_CNT);
      push_item.row = f1_row;
      push_item.col = f1_col;
    end
  end

  assign push_valid = f1_valid;

endmodule
`default_nettype wire

// File: design/jsfh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module jsfh_queue
  import jsfh_pkg::*;
#(
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  jsfh_item_t       push_item,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output jsfh_item_t       pop_item
);

  jsfh_item_t   slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = (count != (AW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: design/jsfh_back.sv
`timescale 1ns / 1ps
`default_nettype none
module jsfh_back
  import jsfh_pkg::*;
#(
  parameter int MAX_POP_SIZE = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  jsfh_item_t q_item,
  jsfh_out_if.source results,
  output logic       busy
);

  localparam int DIM   = MAX_POP_SIZE + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + CNT_W + 1;

  logic             clr_active;
  logic [AW-1:0]    clr_addr;

  logic             s1_valid;
  jsfh_item_t       s1_item;
  logic [AW-1:0]    s1_addr;

  logic             lw_valid;
  logic [AW-1:0]    lw_addr;
  logic [BIN_W-1:0] lw_data;

  logic             o_valid;
  logic [CNT_W-1:0] o_freq1;
  logic [CNT_W-1:0] o_freq2;
  logic [BIN_W-1:0] o_bin;
  logic [BIN_W-1:0] o_total;
  logic [BIN_W-1:0] site_total;

  logic [PW-1:0]    q_prod;
  logic [AW-1:0]    q_addr;
  logic             pop;
  logic             s1_adv;
  logic             tally;
  logic [BIN_W-1:0] rdata;
  logic [BIN_W-1:0] cur;
  logic [BIN_W-1:0] bumped;
  logic [BIN_W-1:0] total_next;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [BIN_W-1:0] wdata;

  assign busy    = clr_active;
  assign q_prod  = PW'(q_item.row) * PW'(DIM) + PW'(q_item.col);
  assign q_addr  = q_prod[AW-1:0];
  assign s1_adv  = s1_valid && (!o_valid || results.ready);
  assign q_ready = !clr_active && (!s1_valid || s1_adv);
  assign pop     = q_valid && q_ready;
  assign tally   = (s1_item.cmd == CMD_TALLY);

  assign cur        = (lw_valid && lw_addr == s1_addr) ? lw_data : rdata;
  assign bumped     = (cur == BIN_MAX) ? cur : cur + 1'b1;
  assign total_next = (site_total == BIN_MAX) ? site_total : site_total + 1'b1;

  always_comb begin
    if (clr_active) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = s1_adv && tally;
      waddr = s1_addr;
      wdata = bumped;
    end
  end

  jsfh_ram #(
    .WIDTH (BIN_W),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (q_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr <= waddr;
      lw_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= q_item;
      s1_addr <= q_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      site_total <= '0;
    end else if (s1_adv && tally) begin
      site_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (tally) begin
        o_freq1 <= s1_item.row;
        o_freq2 <= s1_item.col;
        o_bin   <= bumped;
        o_total <= total_next;
      end else begin
        o_freq1 <= '0;
        o_freq2 <= '0;
        o_bin   <= s1_item.ok ? cur : '0;
        o_total <= site_total;
      end
    end
  end

  assign results.valid       = o_valid;
  assign results.freq_pop1   = o_freq1;
  assign results.freq_pop2   = o_freq2;
  assign results.bin_value   = o_bin;
  assign results.total_sites = o_total;

endmodule
`default_nettype wire

// File: design/joint_site_frequency_histogram.sv
// channel   dir  payload                                          request taken
// sites     in   cmd, pop1_alleles, pop2_alleles, read_row/col    valid & ready
// results   out  freq_pop1, freq_pop2, bin_value, total_sites     valid & ready
// cfg       in   cfg_index, cfg_data                              cfg_we
//
// One request per cycle sustained while results.ready is high; from acceptance to result
// taken a request passes one front stage (masked popcount, summed at its output), the
// queue, the bin read, the result register. Bin read-modify-write, with write forwarding,
// runs at the same rate. After reset a clearing pass zeroes all (MAX_POP_SIZE+1)^2 bins,
// one per cycle; sites.ready stays low until it ends.
// A four-entry queue lets the front keep accepting while results stall.
`timescale 1ns / 1ps
`default_nettype none
module joint_site_frequency_histogram
  import jsfh_pkg::*;
#(
  parameter int MAX_POP_SIZE = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  jsfh_in_if.sink                   sites,
  jsfh_out_if.source                results,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CNT_W-1:0] pop1_size;
  logic [CNT_W-1:0] pop2_size;
  logic             busy;
  logic             push_valid;
  logic             push_ready;
  jsfh_item_t       push_item;
  logic             q_valid;
  logic             q_ready;
  jsfh_item_t       q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop1_size <= SIZE_RESET;
      pop2_size <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POP1: pop1_size <= cfg_data;
        CFG_POP2: pop2_size <= cfg_data;
        default: ;
      endcase
    end
  end

  jsfh_front #(
    .MAX_POP_SIZE (MAX_POP_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .busy       (busy),
    .pop1_size  (pop1_size),
    .pop2_size  (pop2_size),
    .sites      (sites),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  jsfh_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  jsfh_back #(
    .MAX_POP_SIZE (MAX_POP_SIZE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .results (results),
    .busy    (busy)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !sites.ready)
    else $error("request accepted during bin clearing");

  a_clear_queue_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_valid)
    else $error("queued request during bin clearing");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("bin clearing restarted outside reset");

endmodule
`default_nettype wire
